>>> rtl/grid_wavefront_path_search_unit_assert.svh
// ----------------------------------------------------------------------------
// grid_wavefront_path_search_unit_assert.svh
// Assertion macros shared by the grid path search RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_WAVEFRONT_PATH_SEARCH_UNIT_ASSERT_SVH
`define GRID_WAVEFRONT_PATH_SEARCH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define GWPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gwps assertion failed");

// expression must never be true outside reset
`define GWPS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("gwps forbidden condition seen");

`else

`define GWPS_ASSERT(label, clk, rst_n, prop)
`define GWPS_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/gwps_pkg.sv
// ----------------------------------------------------------------------------
// gwps_pkg
// Types and constants of the grid wavefront path search unit.
// ----------------------------------------------------------------------------
package gwps_pkg;

    localparam int MAX_WIDTH_DEF  = 8;
    localparam int MAX_HEIGHT_DEF = 8;

    localparam int COORD_W   = 3;
    localparam int SIZE_W    = 4;
    localparam int DIST_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // neighbour order used by both the sweep and the trace-back
    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XM = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_CLEAR     = 10'b00_0000_0010,
        S_SCAN_RD   = 10'b00_0000_0100,
        S_SCAN_CHK  = 10'b00_0000_1000,
        S_NB_RD     = 10'b00_0001_0000,
        S_NB_CHK    = 10'b00_0010_0000,
        S_SWEEP_END = 10'b00_0100_0000,
        S_TR_RD     = 10'b00_1000_0000,
        S_TR_CHK    = 10'b01_0000_0000,
        S_EMIT      = 10'b10_0000_0000
    } t_state;

endpackage

>>> rtl/gwps_ram.sv
// ----------------------------------------------------------------------------
// gwps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gwps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/grid_wavefront_path_search_unit.sv
// ----------------------------------------------------------------------------
// grid_wavefront_path_search_unit
// Lee maze router: obstacle grid, breadth-first wave expansion, trace-back.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one obstacle bit. A search word (func 1) first
// runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries of the distance
// memory (64 at the default size) that also marks the start cell, then sweeps
// the grid in row-major order once per wave level: each cell is read, a cell
// on the current level then reads and checks each in-grid neighbour and skips
// each direction that leaves the grid, and the sweep closes with an end step.
// The trace-back reads and checks the in-grid neighbours of each path cell in
// the same way and then outputs the cell. The sweep and the trace-back share
// the single registered read port of the distance memory. The block takes no
// new word while a search runs; a search with an out-of-grid start answers at
// once. Path cells come out from the end side, followed by one summary word
// with last set.
module grid_wavefront_path_search_unit
    import gwps_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [COORD_W-1:0]   i_cell_x,
    input  logic [COORD_W-1:0]   i_cell_y,
    input  logic                 i_blocked,
    input  logic [COORD_W-1:0]   i_start_x,
    input  logic [COORD_W-1:0]   i_start_y,
    input  logic [COORD_W-1:0]   i_end_x,
    input  logic [COORD_W-1:0]   i_end_y,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COORD_W-1:0]   o_path_x,
    output logic [COORD_W-1:0]   o_path_y,
    output logic                 o_found,
    output logic [DIST_W-1:0]    o_path_length,
    output logic                 o_last,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

`include "grid_wavefront_path_search_unit_assert.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
        return AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // control state
    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_cfg_w, r_cfg_h;
    logic                r_obs_vld [DEPTH];
    logic                r_obs_vld_q;
    logic [DIST_W-1:0]   r_level, n_level;
    logic                r_out_valid, n_out_valid;

    // search datapath
    logic [COORD_W-1:0]  r_sx, n_sx, r_sy, n_sy, r_ex, n_ex, r_ey, n_ey;
    logic [COORD_W-1:0]  r_x, n_x, r_y, n_y;
    logic [COORD_W-1:0]  r_cx, n_cx, r_cy, n_cy, r_bx, n_bx, r_by, n_by;
    logic [1:0]          r_k, n_k;
    logic [DIST_W-1:0]   r_i, n_i, r_len, n_len;
    logic                r_added, n_added, r_found, n_found;
    logic                r_emit_last, n_emit_last;
    logic [AW-1:0]       r_clr, n_clr;

    // output word
    logic [COORD_W-1:0]  r_path_x, n_path_x, r_path_y, n_path_y;
    logic                r_found_o, n_found_o, r_last_o, n_last_o;
    logic [DIST_W-1:0]   r_len_o, n_len_o;

    logic                in_accept, cfg_accept, out_free;
    logic [SIZE_W-1:0]   eff_w, eff_h;
    logic                load_ok, start_ok;

    // shared neighbour unit
    logic                tracing;
    logic [COORD_W-1:0]  base_x, base_y;
    logic [SIZE_W-1:0]   nx4, ny4;
    logic                nb_dir_ok, nb_ok, nb_free, nb_is_end;
    logic [COORD_W-1:0]  nb_x, nb_y;
    logic [AW-1:0]       nb_addr;

    // sweep cell stepping
    logic                last_x, last_y;
    logic [COORD_W-1:0]  adv_x, adv_y;
    t_state              adv_state;
    logic                tr_hit;
    logic [COORD_W-1:0]  sel_bx, sel_by;

    // memory ports
    logic                dist_we, obs_we;
    logic [AW-1:0]       dist_waddr, rd_addr;
    logic [DIST_W-1:0]   dist_wdata, dist_rdata;
    logic                obs_rdata;

    assign in_accept   = i_in_valid && o_in_ready;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    assign eff_w = (r_cfg_w == '0) ? SIZE_W'(1) :
                   (r_cfg_w > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : r_cfg_w;
    assign eff_h = (r_cfg_h == '0) ? SIZE_W'(1) :
                   (r_cfg_h > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : r_cfg_h;

    assign load_ok  = (int'(i_cell_x) < MAX_WIDTH) && (int'(i_cell_y) < MAX_HEIGHT);
    assign start_ok = (SIZE_W'(i_start_x) < eff_w) && (SIZE_W'(i_start_y) < eff_h);

    assign tracing = (r_state == S_TR_RD) || (r_state == S_TR_CHK);
    assign base_x  = tracing ? r_cx : r_x;
    assign base_y  = tracing ? r_cy : r_y;

    always_comb begin
        nx4       = SIZE_W'(base_x);
        ny4       = SIZE_W'(base_y);
        nb_dir_ok = 1'b1;
        unique case (r_k)
            DIR_XP: nx4 = SIZE_W'(base_x) + SIZE_W'(1);
            DIR_XM: begin
                nx4       = SIZE_W'(base_x) - SIZE_W'(1);
                nb_dir_ok = (base_x != '0);
            end
            DIR_YP: ny4 = SIZE_W'(base_y) + SIZE_W'(1);
            DIR_YM: begin
                ny4       = SIZE_W'(base_y) - SIZE_W'(1);
                nb_dir_ok = (base_y != '0);
            end
        endcase
    end

    assign nb_ok     = nb_dir_ok && (nx4 < eff_w) && (ny4 < eff_h);
    assign nb_x      = nx4[COORD_W-1:0];
    assign nb_y      = ny4[COORD_W-1:0];
    assign nb_addr   = cell_addr(nb_x, nb_y);
    assign nb_free   = !(r_obs_vld_q && obs_rdata);
    assign nb_is_end = (nb_x == r_ex) && (nb_y == r_ey);

    assign last_x    = (SIZE_W'(r_x) == eff_w - SIZE_W'(1));
    assign last_y    = (SIZE_W'(r_y) == eff_h - SIZE_W'(1));
    assign adv_x     = last_x ? '0 : r_x + COORD_W'(1);
    assign adv_y     = last_x ? r_y + COORD_W'(1) : r_y;
    assign adv_state = (last_x && last_y) ? S_SWEEP_END : S_SCAN_RD;

    assign tr_hit = (dist_rdata == r_i);
    assign sel_bx = tr_hit ? nb_x : r_bx;
    assign sel_by = tr_hit ? nb_y : r_by;

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_x         = r_x;
        n_y         = r_y;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_bx        = r_bx;
        n_by        = r_by;
        n_k         = r_k;
        n_i         = r_i;
        n_len       = r_len;
        n_added     = r_added;
        n_found     = r_found;
        n_emit_last = r_emit_last;
        n_clr       = r_clr;
        dist_we     = 1'b0;
        dist_waddr  = nb_addr;
        dist_wdata  = r_level + DIST_W'(1);
        rd_addr     = nb_addr;
        obs_we      = 1'b0;

        n_out_valid = r_out_valid && !i_out_ready;
        n_path_x    = r_path_x;
        n_path_y    = r_path_y;
        n_found_o   = r_found_o;
        n_len_o     = r_len_o;
        n_last_o    = r_last_o;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_func == FUNC_LOAD) begin
                        obs_we = load_ok;
                    end else begin
                        n_sx        = i_start_x;
                        n_sy        = i_start_y;
                        n_ex        = i_end_x;
                        n_ey        = i_end_y;
                        n_level     = '0;
                        n_found     = 1'b0;
                        n_len       = '0;
                        n_clr       = '0;
                        n_emit_last = !start_ok;
                        n_state     = start_ok ? S_CLEAR : S_EMIT;
                    end
                end
            end
            S_CLEAR: begin
                // the start cell is written with distance one on the way
                dist_we    = 1'b1;
                dist_waddr = r_clr;
                dist_wdata = (r_clr == cell_addr(r_sx, r_sy)) ? DIST_W'(1) : '0;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_level = DIST_W'(1);
                    n_x     = '0;
                    n_y     = '0;
                    n_added = 1'b0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_SCAN_RD: begin
                rd_addr = cell_addr(r_x, r_y);
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (dist_rdata == r_level) begin
                    n_k     = DIR_XP;
                    n_state = S_NB_RD;
                end else begin
                    n_x     = adv_x;
                    n_y     = adv_y;
                    n_state = adv_state;
                end
            end
            S_NB_RD: begin
                if (nb_ok) begin
                    n_state = S_NB_CHK;
                end else if (r_k == DIR_YM) begin
                    n_x     = adv_x;
                    n_y     = adv_y;
                    n_state = adv_state;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_NB_CHK: begin
                if (nb_free && (dist_rdata == '0)) begin
                    dist_we = 1'b1;
                    n_added = 1'b1;
                    if (nb_is_end) begin
                        n_found = 1'b1;
                    end
                end
                if (r_k == DIR_YM) begin
                    n_x     = adv_x;
                    n_y     = adv_y;
                    n_state = adv_state;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_NB_RD;
                end
            end
            S_SWEEP_END: begin
                if (r_found) begin
                    n_len       = r_level;
                    n_i         = r_level;
                    n_cx        = r_ex;
                    n_cy        = r_ey;
                    n_bx        = r_ex;
                    n_by        = r_ey;
                    n_k         = DIR_XP;
                    n_emit_last = (r_level < DIST_W'(2));
                    n_state     = (r_level < DIST_W'(2)) ? S_EMIT : S_TR_RD;
                end else if (!r_added) begin
                    n_emit_last = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    n_level = r_level + DIST_W'(1);
                    n_x     = '0;
                    n_y     = '0;
                    n_added = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_TR_RD: begin
                if (nb_ok) begin
                    n_state = S_TR_CHK;
                end else if (r_k == DIR_YM) begin
                    n_cx    = r_bx;
                    n_cy    = r_by;
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_TR_CHK: begin
                // later directions override earlier hits
                n_bx = sel_bx;
                n_by = sel_by;
                if (r_k == DIR_YM) begin
                    n_cx    = sel_bx;
                    n_cy    = sel_by;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_TR_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_emit_last) begin
                        n_path_x  = '0;
                        n_path_y  = '0;
                        n_found_o = r_found;
                        n_len_o   = r_len;
                        n_last_o  = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_path_x  = r_cx;
                        n_path_y  = r_cy;
                        n_found_o = 1'b0;
                        n_len_o   = '0;
                        n_last_o  = 1'b0;
                        if (r_i <= DIST_W'(2)) begin
                            n_emit_last = 1'b1;
                        end else begin
                            n_i     = r_i - DIST_W'(1);
                            n_k     = DIR_XP;
                            n_state = S_TR_RD;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
            r_cfg_w     <= SIZE_RESET;
            r_cfg_h     <= SIZE_RESET;
            for (int j = 0; j < DEPTH; j++) begin
                r_obs_vld[j] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_GRID_HEIGHT: r_cfg_h <= i_cfg_data;
                endcase
            end
            if (obs_we) begin
                r_obs_vld[cell_addr(i_cell_x, i_cell_y)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_obs_vld_q <= r_obs_vld[rd_addr];
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_ex        <= n_ex;
        r_ey        <= n_ey;
        r_x         <= n_x;
        r_y         <= n_y;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_bx        <= n_bx;
        r_by        <= n_by;
        r_k         <= n_k;
        r_i         <= n_i;
        r_len       <= n_len;
        r_added     <= n_added;
        r_found     <= n_found;
        r_emit_last <= n_emit_last;
        r_clr       <= n_clr;
        r_path_x    <= n_path_x;
        r_path_y    <= n_path_y;
        r_found_o   <= n_found_o;
        r_len_o     <= n_len_o;
        r_last_o    <= n_last_o;
    end

    gwps_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dist_rdata)
    );

    gwps_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_obs_ram (
        .i_clk   (i_clk),
        .i_we    (obs_we),
        .i_waddr (cell_addr(i_cell_x, i_cell_y)),
        .i_wdata (i_blocked),
        .i_raddr (rd_addr),
        .o_rdata (obs_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_path_x      = r_path_x;
    assign o_path_y      = r_path_y;
    assign o_found       = r_found_o;
    assign o_path_length = r_len_o;
    assign o_last        = r_last_o;

    // a wave write must target an in-grid neighbour
    `GWPS_ASSERT(a_wave_write_in_grid, i_clk, i_rst_n, ((r_state == S_NB_CHK) && dist_we) |-> nb_ok)
    // trace-back only runs for distances above one
    `GWPS_NEVER(a_trace_level_low, i_clk, i_rst_n, tracing && (r_i < DIST_W'(2)))
    // a search word always leaves idle on the next cycle
    `GWPS_ASSERT(a_search_busy, i_clk, i_rst_n, (in_accept && (i_func == FUNC_SEARCH)) |=> !o_in_ready)
    // clearing pass stays within the memory
    `GWPS_NEVER(a_clear_range, i_clk, i_rst_n, (r_state == S_CLEAR) && (int'(r_clr) >= DEPTH))

endmodule
